/* src/assert_macros.svh */
// Assertion shorthands shared by the RTL; each expects clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check a consequence in the same cycle as its trigger.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its trigger.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/lkv_pkg.sv */
`default_nettype none

package lkv_pkg;

  localparam int CAP_W = 5;
  localparam int KEY_W = 32;
  localparam int VAL_W = 32;

  // Operation codes
  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  localparam logic [CAP_W-1:0] CAP_RESET  = 5'd16;
  localparam logic [VAL_W-1:0] MISS_VALUE = '1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;     // latch the incoming item
    logic match;    // register the compare results
    logic apply;    // update entries and read or write the value store
    logic cfg_wr;   // take a new capacity
    logic trim;     // drop the oldest entry while above capacity
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic over_cap;
  } sts_t;

endpackage

`default_nettype wire

/* src/lkv_ctrl.sv */
`default_nettype none

`include "assert_macros.svh"

module lkv_ctrl (
  input  wire           clk,
  input  wire           rst,
  input  wire           in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  wire           out_stall,
  input  wire           cfg_valid,
  output logic          cfg_ready,
  output lkv_pkg::cmd_t cmd,
  input  lkv_pkg::sts_t sts
);
  import lkv_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MATCH = 3'd1;
  localparam logic [2:0] S_APPLY = 3'd2;
  localparam logic [2:0] S_OUT   = 3'd3;
  localparam logic [2:0] S_TRIM  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       in_fire;
  logic       cfg_fire;

  // Handshakes: a configuration beat wins over an item in the same cycle
  assign cfg_ready = (state == S_IDLE);
  assign in_stall  = !((state == S_IDLE) && !cfg_valid);
  assign out_valid = (state == S_OUT);
  assign in_fire   = in_valid && !in_stall;
  assign cfg_fire  = cfg_valid && cfg_ready;

  // Advance through the item and capacity-write sequences
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cfg_fire) begin
          state_next = S_TRIM;
        end else if (in_fire) begin
          state_next = S_MATCH;
        end
      end
      S_MATCH: state_next = S_APPLY;
      S_APPLY: state_next = S_OUT;
      S_OUT: begin
        if (!out_stall) begin
          state_next = S_IDLE;
        end
      end
      S_TRIM: begin
        if (!sts.over_cap) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Drive datapath commands
  always_comb begin
    cmd        = '0;
    cmd.load   = in_fire;
    cmd.match  = (state == S_MATCH);
    cmd.apply  = (state == S_APPLY);
    cmd.cfg_wr = cfg_fire;
    cmd.trim   = (state == S_TRIM);
  end

  `ASSERT_IMPLIES(a_busy_stalls, state != S_IDLE, in_stall, "item taken while busy")
  `ASSERT_NEXT(a_accept_matches, in_fire, state == S_MATCH, "accepted item not matched")
  `ASSERT_NEXT(a_cfg_trims, cfg_fire, state == S_TRIM && !out_valid, "capacity write not trimmed")

endmodule

`default_nettype wire

/* src/lkv_dpath.sv */
`default_nettype none

`include "assert_macros.svh"

module lkv_dpath #(
  parameter int ENTRIES = 16
) (
  input  wire                                clk,
  input  wire                                rst,
  input  lkv_pkg::cmd_t                      cmd,
  output lkv_pkg::sts_t                      sts,
  input  wire                                opcode,
  input  wire signed [lkv_pkg::KEY_W-1:0]    lookup_key,
  input  wire signed [lkv_pkg::VAL_W-1:0]    write_value,
  input  wire        [lkv_pkg::CAP_W-1:0]    capacity,
  output logic                               found,
  output logic signed [lkv_pkg::VAL_W-1:0]   read_value
);
  import lkv_pkg::*;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);

  // Latched item
  logic             op_q;
  logic [KEY_W-1:0] key_q;
  logic [VAL_W-1:0] val_q;

  // Entry state
  logic [KEY_W-1:0]   keys   [ENTRIES];
  logic [IDX_W-1:0]   rank   [ENTRIES];
  logic [VAL_W-1:0]   values [ENTRIES];
  logic [ENTRIES-1:0] valid;
  logic [CNT_W-1:0]   live;
  logic [CAP_W-1:0]   cap;

  // Compare results
  logic [ENTRIES-1:0] hit_vec;
  logic [ENTRIES-1:0] old_oh;
  logic [ENTRIES-1:0] free_oh;
  logic [IDX_W-1:0]   hit_enc;
  logic [IDX_W-1:0]   old_enc;
  logic [IDX_W-1:0]   free_enc;
  logic [IDX_W-1:0]   hit_rank_c;
  logic [IDX_W-1:0]   old_rank;
  logic [CNT_W-1:0]   eff_cap;
  logic               full;

  // Registered match
  logic               hit_q;
  logic [IDX_W-1:0]   hit_idx;
  logic [IDX_W-1:0]   hit_rank;
  logic [ENTRIES-1:0] slot_oh;
  logic [IDX_W-1:0]   slot_idx;
  logic               fill_q;

  // Result
  logic             found_q;
  logic             use_rdata;
  logic [VAL_W-1:0] rdata;

  logic upd_rank;
  logic new_entry;

  // Clamp capacity to 1 .. ENTRIES
  always_comb begin
    if (cap == '0) begin
      eff_cap = CNT_W'(1);
    end else if (32'(cap) > 32'(ENTRIES)) begin
      eff_cap = CNT_W'(ENTRIES);
    end else begin
      eff_cap = CNT_W'(cap);
    end
  end

  assign full         = (live >= eff_cap);
  assign sts.over_cap = (live > eff_cap);
  assign old_rank     = IDX_W'(live - CNT_W'(1));

  // Compare every entry in parallel; the oldest live entry has rank live-1
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      hit_vec[i] = valid[i] && (keys[i] == key_q);
      old_oh[i]  = valid[i] && (rank[i] == old_rank);
    end
  end

  // Lowest free slot as a one-hot
  assign free_oh = ~valid & (valid + ENTRIES'(1));

  // Encode one-hots to indexes
  always_comb begin
    hit_enc    = '0;
    old_enc    = '0;
    free_enc   = '0;
    hit_rank_c = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (hit_vec[i]) begin
        hit_enc    = hit_enc | IDX_W'(i);
        hit_rank_c = hit_rank_c | rank[i];
      end
      if (old_oh[i]) begin
        old_enc = old_enc | IDX_W'(i);
      end
      if (free_oh[i]) begin
        free_enc = free_enc | IDX_W'(i);
      end
    end
  end

  // Latch the item
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q  <= opcode;
      key_q <= lookup_key;
      val_q <= write_value;
    end
  end

  // Register the match and pick the target slot
  always_ff @(posedge clk) begin
    if (cmd.match) begin
      hit_q    <= |hit_vec;
      hit_idx  <= hit_enc;
      hit_rank <= hit_rank_c;
      fill_q   <= !full;
      if (|hit_vec) begin
        slot_oh  <= hit_vec;
        slot_idx <= hit_enc;
      end else if (full) begin
        slot_oh  <= old_oh;
        slot_idx <= old_enc;
      end else begin
        slot_oh  <= free_oh;
        slot_idx <= free_enc;
      end
    end
  end

  assign upd_rank  = cmd.apply && ((op_q == OP_PUT) || hit_q);
  assign new_entry = cmd.apply && (op_q == OP_PUT) && !hit_q;

  // Valid bits, live count and capacity
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      live  <= '0;
      cap   <= CAP_RESET;
    end else begin
      if (cmd.cfg_wr) begin
        cap <= capacity;
      end
      if (cmd.trim && sts.over_cap) begin
        valid <= valid & ~old_oh;
        live  <= live - CNT_W'(1);
      end
      if (new_entry && fill_q) begin
        valid <= valid | slot_oh;
        live  <= live + CNT_W'(1);
      end
    end
  end

  // Promote the target slot; push newer entries back by one
  always_ff @(posedge clk) begin
    if (upd_rank) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (slot_oh[i]) begin
          rank[i] <= '0;
        end else if (valid[i] && (!hit_q || (rank[i] < hit_rank))) begin
          rank[i] <= rank[i] + IDX_W'(1);
        end
      end
    end
  end

  // Store a new key
  always_ff @(posedge clk) begin
    if (new_entry) begin
      keys[slot_idx] <= key_q;
    end
  end

  // Value store: write on put, registered read on get hit
  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      if (op_q == OP_PUT) begin
        values[slot_idx] <= val_q;
      end else if (hit_q) begin
        rdata <= values[hit_idx];
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      found_q   <= hit_q;
      use_rdata <= hit_q && (op_q == OP_GET);
    end
  end

  assign found      = found_q;
  assign read_value = use_rdata ? rdata : MISS_VALUE;

  `ASSERT_ALWAYS(a_live_count, $countones(valid) == int'(live), "live count off")
  `ASSERT_ALWAYS(a_hit_unique, $onehot0(hit_vec), "key held twice")
  `ASSERT_IMPLIES(a_fill_free, new_entry && fill_q, (slot_oh & valid) == '0, "fill of used slot")

endmodule

`default_nettype wire

/* src/lru_key_value_cache.sv */
// Channel   Dir  Handshake             Beat payload
// in        in   in_valid / in_stall   opcode, lookup_key, write_value
// out       out  out_valid / out_stall found, read_value
// cfg       in   cfg_valid / cfg_ready capacity
//
// An item passes through accept, key compare, entry update with value store
// access and result before the next item beat is taken. The one-at-a-time
// sequencer takes no new item or capacity beat while one is in flight.
// A capacity write goes to the trim state, which drops the oldest entries
// until the live count is within capacity before the next beat is taken.
// Reset is synchronous and clears all entries; capacity returns to 16.
// A stalled result holds, and no item is taken until it leaves.
`default_nettype none

module lru_key_value_cache #(
  parameter int ENTRIES = 16
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              in_valid,
  output logic                             in_stall,
  input  wire                              opcode,
  input  wire signed [lkv_pkg::KEY_W-1:0]  lookup_key,
  input  wire signed [lkv_pkg::VAL_W-1:0]  write_value,
  output logic                             out_valid,
  input  wire                              out_stall,
  output logic                             found,
  output logic signed [lkv_pkg::VAL_W-1:0] read_value,
  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire        [lkv_pkg::CAP_W-1:0]  capacity
);
  import lkv_pkg::*;

  cmd_t cmd;
  sts_t sts;

  lkv_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  lkv_dpath #(
    .ENTRIES (ENTRIES)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .opcode      (opcode),
    .lookup_key  (lookup_key),
    .write_value (write_value),
    .capacity    (capacity),
    .found       (found),
    .read_value  (read_value)
  );

endmodule

`default_nettype wire

/* test/lru_key_value_cache_checker.sv */
`timescale 1ns / 100ps

// Watch the item, result and capacity channels of the cache, track the
// expected contents and recency order, and compare every result beat.
module lru_key_value_cache_checker #(
  parameter int ENTRIES = 16
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              in_valid,
  input  wire                              in_stall,
  input  wire                              opcode,
  input  wire        [lkv_pkg::KEY_W-1:0]  lookup_key,
  input  wire        [lkv_pkg::VAL_W-1:0]  write_value,
  input  wire                              out_valid,
  input  wire                              out_stall,
  input  wire                              found,
  input  wire        [lkv_pkg::VAL_W-1:0]  read_value,
  input  wire                              cfg_valid,
  input  wire                              cfg_ready,
  input  wire        [lkv_pkg::CAP_W-1:0]  capacity,
  output int                               errors,
  output int                               pending
);

  typedef struct packed {
    logic                      hit;
    logic [lkv_pkg::VAL_W-1:0] value;
  } lookup_reply_t;

  // Shadow of the cache contents; age 0 is the most recent entry
  logic [lkv_pkg::KEY_W-1:0] slot_key   [ENTRIES];
  logic [lkv_pkg::VAL_W-1:0] slot_value [ENTRIES];
  bit                        slot_live  [ENTRIES];
  int unsigned               slot_age   [ENTRIES];
  int unsigned               live_slots;
  logic [lkv_pkg::CAP_W-1:0] cap_reg;

  lookup_reply_t lookup_replies_q[$];
  lookup_reply_t oldest;

  function automatic void clear_cache();
    cap_reg    = lkv_pkg::CAP_RESET;
    live_slots = 0;
    for (int i = 0; i < ENTRIES; i++) begin
      slot_key[i]   = '0;
      slot_value[i] = '0;
      slot_live[i]  = 1'b0;
      slot_age[i]   = 0;
    end
  endfunction

  // Zero acts as one, anything above the entry count as the entry count
  function automatic int unsigned usable_capacity();
    if (cap_reg == '0) return 1;
    if (cap_reg > ENTRIES) return ENTRIES;
    return cap_reg;
  endfunction

  function automatic int unsigned least_recent_slot();
    int unsigned pick;
    int unsigned pick_age;
    bit          seen;
    pick     = 0;
    pick_age = 0;
    seen     = 1'b0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (slot_live[i] && (!seen || slot_age[i] > pick_age)) begin
        pick     = i;
        pick_age = slot_age[i];
        seen     = 1'b1;
      end
    end
    return pick;
  endfunction

  // Move slot s to the front; entries newer than limit age by one
  function automatic void make_newest(int unsigned s, int unsigned limit);
    for (int i = 0; i < ENTRIES; i++)
      if (slot_live[i] && i != s && slot_age[i] < limit) slot_age[i]++;
    slot_age[s] = 0;
  endfunction

  // Take a new capacity and drop the oldest entries until within it
  function automatic void set_capacity(logic [lkv_pkg::CAP_W-1:0] value);
    int unsigned s;
    cap_reg = value;
    while (live_slots > usable_capacity()) begin
      s            = least_recent_slot();
      slot_live[s] = 1'b0;
      slot_age[s]  = 0;
      live_slots--;
    end
  endfunction

  function automatic lookup_reply_t lru_access(logic op, logic [lkv_pkg::KEY_W-1:0] key,
                                               logic [lkv_pkg::VAL_W-1:0] value);
    lookup_reply_t reply;
    int unsigned   hit_slot;
    int unsigned   fill_slot;
    bit            hit;
    hit      = 1'b0;
    hit_slot = 0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (!hit && slot_live[i] && slot_key[i] == key) begin
        hit      = 1'b1;
        hit_slot = i;
      end
    end
    reply.hit   = hit;
    reply.value = lkv_pkg::MISS_VALUE;

    if (op == lkv_pkg::OP_GET) begin
      if (hit) begin
        reply.value = slot_value[hit_slot];
        make_newest(hit_slot, slot_age[hit_slot]);
      end
    end else if (hit) begin
      slot_value[hit_slot] = value;
      make_newest(hit_slot, slot_age[hit_slot]);
    end else begin
      // Reuse the oldest slot when full, else the lowest free one
      fill_slot = 0;
      if (live_slots >= usable_capacity()) begin
        fill_slot            = least_recent_slot();
        slot_live[fill_slot] = 1'b0;
        live_slots--;
      end else begin
        for (int i = ENTRIES - 1; i >= 0; i--)
          if (!slot_live[i]) fill_slot = i;
      end
      make_newest(fill_slot, 32'hFFFF_FFFF);
      slot_key[fill_slot]   = key;
      slot_value[fill_slot] = value;
      slot_live[fill_slot]  = 1'b1;
      live_slots++;
    end
    return reply;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      clear_cache();
      lookup_replies_q.delete();
      errors = 0;
    end else begin
      // Check a result beat against the oldest prediction
      if (out_valid && !out_stall) begin
        if (lookup_replies_q.size() == 0) begin
          $display("%0t: unexpected result beat, found %0b read_value %h",
                   $time, found, read_value);
          errors++;
        end else begin
          oldest = lookup_replies_q.pop_front();
          if (found !== oldest.hit) begin
            $display("%0t: found mismatch, expected %0b, actual %0b",
                     $time, oldest.hit, found);
            errors++;
          end
          if (read_value !== oldest.value) begin
            $display("%0t: read_value mismatch, expected %h, actual %h",
                     $time, oldest.value, read_value);
            errors++;
          end
        end
      end
      if (cfg_valid && cfg_ready) set_capacity(capacity);
      // Predict the result of an item beat
      if (in_valid && !in_stall)
        lookup_replies_q.push_back(lru_access(opcode, lookup_key, write_value));
    end
    pending = lookup_replies_q.size();
  end

endmodule

/* test/lru_key_value_cache_test.sv */
`timescale 1ns / 100ps

module lru_key_value_cache_test;

  localparam int ENTRIES         = 16;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int RANDOM_PHASES   = 9;
  localparam int ITEMS_PER_PHASE = 50;
  localparam int KEY_POOL        = 20;

  logic                              clk;
  logic                              rst;
  logic                              in_valid;
  logic                              in_stall;
  logic                              opcode;
  logic signed [lkv_pkg::KEY_W-1:0]  lookup_key;
  logic signed [lkv_pkg::VAL_W-1:0]  write_value;
  logic                              out_valid;
  logic                              out_stall;
  logic                              found;
  logic signed [lkv_pkg::VAL_W-1:0]  read_value;
  logic                              cfg_valid;
  logic                              cfg_ready;
  logic        [lkv_pkg::CAP_W-1:0]  capacity;

  int errors;
  int pending;
  int send_idle;
  int recv_idle;
  int cycle_count = 0;

  logic [lkv_pkg::KEY_W-1:0] key_pool[KEY_POOL];
  logic [lkv_pkg::CAP_W-1:0] phase_caps[RANDOM_PHASES] =
    '{5'd3, 5'd1, 5'd0, 5'd16, 5'd31, 5'd17, 5'd5, 5'd12, 5'd2};

  lru_key_value_cache #(
    .ENTRIES(ENTRIES)
  ) u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .opcode     (opcode),
    .lookup_key (lookup_key),
    .write_value(write_value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .found      (found),
    .read_value (read_value),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .capacity   (capacity)
  );

  lru_key_value_cache_checker #(
    .ENTRIES(ENTRIES)
  ) u_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .opcode     (opcode),
    .lookup_key (lookup_key),
    .write_value(write_value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .found      (found),
    .read_value (read_value),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .capacity   (capacity),
    .errors     (errors),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Stall the result channel at random
  always @(negedge clk) begin
    out_stall = !rst && ($urandom_range(99) < recv_idle);
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Send one item beat; idle first at random, hold until taken
  task automatic send_item(input logic op, input logic [lkv_pkg::KEY_W-1:0] key,
                           input logic [lkv_pkg::VAL_W-1:0] value);
    while ($urandom_range(99) < send_idle) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    opcode      = op;
    lookup_key  = key;
    write_value = value;
    in_valid    = 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Wait until every result is back and the block has settled
  task automatic drain();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_capacity(input logic [lkv_pkg::CAP_W-1:0] value);
    drain();
    capacity  = value;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Mostly pool keys so that hits and evictions happen, now and then a fresh key
  task automatic send_random(input int pool_span);
    logic [lkv_pkg::KEY_W-1:0] key;
    logic [lkv_pkg::VAL_W-1:0] value;
    if ($urandom_range(99) < 12) key = $urandom;
    else key = key_pool[$urandom_range(pool_span - 1)];
    case ($urandom_range(15))
      0:       value = 32'h8000_0000;
      1:       value = 32'h7FFF_FFFF;
      default: value = $urandom;
    endcase
    send_item($urandom_range(1) ? lkv_pkg::OP_PUT : lkv_pkg::OP_GET, key, value);
  endtask

  initial begin
    int pool_span;
    rst         = 1'b1;
    in_valid    = 1'b0;
    opcode      = lkv_pkg::OP_GET;
    lookup_key  = '0;
    write_value = '0;
    out_stall   = 1'b0;
    cfg_valid   = 1'b0;
    capacity    = lkv_pkg::CAP_RESET;
    send_idle   = 24;
    recv_idle   = 45;
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7FFF_FFFF;
    key_pool[2] = 32'h0000_0000;
    key_pool[3] = 32'hFFFF_FFFF;
    for (int i = 4; i < KEY_POOL; i++) key_pool[i] = $urandom;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: empty miss, extreme keys and values, hits, update, ignored value
    send_item(lkv_pkg::OP_GET, 32'h0000_0000, $urandom);
    send_item(lkv_pkg::OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    send_item(lkv_pkg::OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    send_item(lkv_pkg::OP_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
    send_item(lkv_pkg::OP_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
    send_item(lkv_pkg::OP_GET, 32'h7FFF_FFFF, $urandom);
    send_item(lkv_pkg::OP_GET, 32'h8000_0000, $urandom);
    send_item(lkv_pkg::OP_PUT, 32'h7FFF_FFFF, 32'h1234_5678);
    send_item(lkv_pkg::OP_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_item(lkv_pkg::OP_GET, 32'h0000_0001, 32'hA5A5_A5A5);
    // Fill every slot, then put a new key into a full cache
    for (int i = 0; i < 12; i++) send_item(lkv_pkg::OP_PUT, 100 + i, $urandom);
    send_item(lkv_pkg::OP_PUT, 32'd200, $urandom);
    send_item(lkv_pkg::OP_GET, 32'hFFFF_FFFF, $urandom);
    send_item(lkv_pkg::OP_GET, 32'h0000_0000, $urandom);

    // Random phases, each under its own capacity; the first one shrinks a full cache
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase / 3)
        0: begin
          send_idle = 24;
          recv_idle = 45;
        end
        1: begin
          send_idle = 45;
          recv_idle = 24;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      write_capacity(phase_caps[phase]);
      repeat (3) key_pool[$urandom_range(KEY_POOL - 1, 4)] = $urandom;
      pool_span = phase_caps[phase] + 4;
      if (pool_span < 5) pool_span = 5;
      if (pool_span > KEY_POOL) pool_span = KEY_POOL;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) send_random(pool_span);
    end

    drain();
    repeat (20) @(negedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+src
src/lkv_pkg.sv
src/lkv_ctrl.sv
src/lkv_dpath.sv
src/lru_key_value_cache.sv
test/lru_key_value_cache_checker.sv
test/lru_key_value_cache_test.sv
